// ===== design/dpf_pkg.sv =====
// Shared types and constants for the deduplicating packet queue.
// Used by dpf_cell, dpf_count and dedup_packet_fifo_with_range_count.
package dpf_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int LIM_W = 7;
    localparam int EXT_W = (OCC_W > LIM_W) ? OCC_W : LIM_W;
    localparam int GRP = 8;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;
    localparam int GCW = $clog2(GRP + 1);
    localparam int MC_W = 7;

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_FWD = 2'd1;
    localparam logic [1:0] FUNC_CNT = 2'd2;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dest;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        entry_t      pkt;
        logic [31:0] ws;
        logic [31:0] we;
    } key_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

// ===== design/dedup_packet_fifo_with_range_count.sv =====
// Top level of the deduplicating packet queue with windowed count.
// Depends on dpf_pkg, dpf_cell and dpf_count.
//
// Usage:
//   Request channel (req_valid / req_stall) carries func and the packet or window
//   fields. func add stores a packet unless an identical one is held, evicting the
//   oldest when the limit is reached; forward pops the oldest; count reports how many
//   held packets match dest_id with a timestamp in [window_start, window_end].
//   Response channel (rsp_valid / rsp_stall) returns one response per request.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the capacity
//   limit; write it only while no request is in flight.
// Timing:
//   A request is compared against all slots in the cycle after acceptance; the queue
//   update and response register load follow in the update state, which holds while
//   a held response blocks the response register. A new request is taken in the
//   update cycle, overlapping the previous update, so the request rate is set by the
//   compare/count stage feeding the update stage.
// Reset: the queue is empty and the limit is 64.
// Stall: a held response freezes the update stage; req_stall stays high until the
//   response register can take the next response.
module dedup_packet_fifo_with_range_count (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  func,
    input  logic [15:0] src_id,
    input  logic [15:0] dest_id,
    input  logic [31:0] packet_time,
    input  logic [31:0] window_start,
    input  logic [31:0] window_end,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic        accepted,
    output logic        popped_valid,
    output logic [15:0] out_src,
    output logic [15:0] out_dest,
    output logic [31:0] out_time,
    output logic [6:0]  match_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import dpf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [LIM_W-1:0] limit_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [1:0]       func_reg;
    key_t             key_reg;
    logic             dup_reg;

    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    logic             accepted_reg;
    logic             popped_reg;
    entry_t           out_pkt_reg;
    logic [MC_W-1:0]  count_reg;
    logic             accepted_next;
    logic             popped_next;
    entry_t           out_pkt_next;
    logic [MC_W-1:0]  count_next;

    logic             out_free;
    logic             req_fire;
    logic             upd_fire;
    logic [EXT_W-1:0] lim_raw;
    logic [EXT_W-1:0] lim_eff;
    logic             evict;
    logic [IDX_W-1:0] wr_idx;
    logic             do_shift;
    logic             do_load;

    logic             cell_vld [DEPTH];
    entry_t           cell_ent [DEPTH];
    logic [DEPTH-1:0] dup_vec;
    logic [DEPTH-1:0] cnt_vec;
    logic [DEPTH-1:0] vld_vec;
    logic [OCC_W-1:0] total;

    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) || ((state_reg == S_UPD) && out_free));
    assign req_fire  = req_valid && !req_stall;
    assign upd_fire  = (state_reg == S_UPD) && out_free;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = req_fire ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = out_free ? (req_fire ? S_CMP : S_IDLE) : S_UPD;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        lim_raw = EXT_W'(limit_reg);
        lim_eff = lim_raw;
        if (lim_raw == '0)
        begin
            lim_eff = EXT_W'(1);
        end
        else if (lim_raw > EXT_W'(DEPTH))
        begin
            lim_eff = EXT_W'(DEPTH);
        end
    end

    assign evict  = EXT_W'(occ_reg) >= lim_eff;
    assign wr_idx = evict ? IDX_W'(occ_reg - OCC_W'(1)) : IDX_W'(occ_reg);

    always_comb
    begin
        do_shift      = 1'b0;
        do_load       = 1'b0;
        occ_next      = occ_reg;
        accepted_next = 1'b0;
        popped_next   = 1'b0;
        out_pkt_next  = '0;
        count_next    = '0;
        unique case (func_reg)
            FUNC_ADD:
            begin
                if (!dup_reg)
                begin
                    do_shift      = evict;
                    do_load       = 1'b1;
                    occ_next      = evict ? occ_reg : occ_reg + OCC_W'(1);
                    accepted_next = 1'b1;
                end
            end
            FUNC_FWD:
            begin
                if (occ_reg != '0)
                begin
                    do_shift     = 1'b1;
                    occ_next     = occ_reg - OCC_W'(1);
                    popped_next  = 1'b1;
                    out_pkt_next = cell_ent[0];
                end
            end
            FUNC_CNT:
            begin
                count_next = MC_W'(total);
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_ctl_t ctl;
            logic      nbr_valid;
            entry_t    nbr;

            assign ctl.shift = upd_fire && do_shift;
            assign ctl.load  = upd_fire && do_load && (wr_idx == IDX_W'(gi));

            if (gi < DEPTH - 1)
            begin : g_mid
                assign nbr_valid = cell_vld[gi+1];
                assign nbr       = cell_ent[gi+1];
            end
            else
            begin : g_last
                assign nbr_valid = 1'b0;
                assign nbr       = '0;
            end

            dpf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .nbr_valid (nbr_valid),
                .nbr       (nbr),
                .key       (key_reg),
                .valid     (cell_vld[gi]),
                .ent       (cell_ent[gi]),
                .dup_hit   (dup_vec[gi]),
                .cnt_hit   (cnt_vec[gi])
            );

            assign vld_vec[gi] = cell_vld[gi];
        end
    endgenerate

    dpf_count u_count (
        .clk   (clk),
        .cap   (state_reg == S_CMP),
        .hits  (cnt_vec),
        .total (total)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (upd_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            occ_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (upd_fire)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    // hold request fields, compare result and response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg    <= func;
            key_reg.pkt <= '{src: src_id, dest: dest_id, stamp: packet_time};
            key_reg.ws  <= window_start;
            key_reg.we  <= window_end;
        end
        if (state_reg == S_CMP)
        begin
            dup_reg <= |dup_vec;
        end
        if (upd_fire)
        begin
            accepted_reg <= accepted_next;
            popped_reg   <= popped_next;
            out_pkt_reg  <= out_pkt_next;
            count_reg    <= count_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign accepted     = accepted_reg;
    assign popped_valid = popped_reg;
    assign out_src      = out_pkt_reg.src;
    assign out_dest     = out_pkt_reg.dest;
    assign out_time     = out_pkt_reg.stamp;
    assign match_count  = count_reg;

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) == int'(occ_reg))
        else $error("slot valid bits disagree with occupancy");

    a_cmp_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |=> (state_reg == S_UPD))
        else $error("compare stage not followed by update");

    a_upd_resp: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire |=> rsp_valid_reg)
        else $error("update without response");
`endif

endmodule

// ===== design/dpf_cell.sv =====
// One queue slot: holds a packet, shifts from its upper neighbor, compares against the key.
// Depends on dpf_pkg.
module dpf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  dpf_pkg::cell_ctl_t ctl,
    input  logic              nbr_valid,
    input  dpf_pkg::entry_t   nbr,
    input  dpf_pkg::key_t     key,
    output logic              valid,
    output dpf_pkg::entry_t   ent,
    output logic              dup_hit,
    output logic              cnt_hit
);
    import dpf_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        valid_next = valid_reg;
        ent_next   = ent_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
            ent_next   = key.pkt;
        end
        else if (ctl.shift)
        begin
            valid_next = nbr_valid;
            ent_next   = nbr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign valid   = valid_reg;
    assign ent     = ent_reg;
    assign dup_hit = valid_reg && (ent_reg == key.pkt);
    assign cnt_hit = valid_reg && (ent_reg.dest == key.pkt.dest)
                     && (ent_reg.stamp >= key.ws) && (ent_reg.stamp <= key.we);

endmodule

// ===== design/dpf_count.sv =====
// Two-level population count of the per-slot window hits, first level registered.
// Depends on dpf_pkg.
module dpf_count (
    input  logic                      clk,
    input  logic                      cap,
    input  logic [dpf_pkg::DEPTH-1:0] hits,
    output logic [dpf_pkg::OCC_W-1:0] total
);
    import dpf_pkg::*;

    logic [NGRP*GRP-1:0] hits_pad;
    logic [GCW-1:0]      grp_reg  [NGRP];
    logic [GCW-1:0]      grp_next [NGRP];

    assign hits_pad = (NGRP*GRP)'(hits);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int b = 0; b < GRP; b++)
            begin
                grp_next[g] = grp_next[g] + GCW'(hits_pad[g*GRP + b]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            grp_reg <= grp_next;
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + OCC_W'(grp_reg[g]);
        end
    end

endmodule
